[hw/rtl/bcss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket counting sort package
// Shared sizes, command and status codes, and the request and response types.
// ----------------------------------------------------------------------------
package bcss_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int MAX_ITEMS   = 4096;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 10;
    localparam int SLOT_W  = 12;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 13;
    localparam int CFG_W   = 11;

    // Table sizes.
    localparam int ADDR_W = $clog2(MAX_BUCKETS);
    localparam int IDX_W  = $clog2(MAX_BUCKETS + 1);
    localparam int VAL_W  = $clog2(MAX_ITEMS + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_KEY_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } bcss_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [STAT_W-1:0]  status;
        logic [TOTAL_W-1:0] total;
    } bcss_rsp_t;

endpackage

[hw/rtl/bucket_counting_sort_slots_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket counting sort slot unit
// Keeps per-bucket counters in a single-port-read, single-port-write memory
// and runs clear, count, prefix and assign requests against it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_stall  bcss_req_t (command, key)
//  rsp       out        rsp_valid/rsp_stall  bcss_rsp_t (slot, status, total)
//  cfg       in         cfg_write            cfg_data (bucket count)
//
//  Count and assign do a memory read, then modify and write back.
//  Clear and prefix step through the buckets in use, both bound by the one
//  write port of the bucket memory.
//  After reset the whole memory is cleared; requests wait meanwhile.
//  One request is in flight at a time; a stalled response is held in a spare
//  register and the unit waits until it can be delivered.
// ----------------------------------------------------------------------------
module bucket_counting_sort_slots_unit
    import bcss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  bcss_req_t        req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output bcss_rsp_t        rsp,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_CLEAR,
        S_PREFIX,
        S_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pf_busy_reg, pf_busy_next;
    logic [ADDR_W-1:0]  pf_addr_reg, pf_addr_next;
    logic [VAL_W-1:0]   sum_reg, sum_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic               key_ok_reg, key_ok_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CFG_W-1:0]   bucket_count_reg;
    bcss_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    bcss_rsp_t          pend_reg, pend_next;

    // Bucket memory.
    logic [VAL_W-1:0]   mem [MAX_BUCKETS];
    logic [VAL_W-1:0]   rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VAL_W-1:0]   wr_data;

    logic [IDX_W-1:0]   used;
    logic               out_free;
    logic               done;
    bcss_rsp_t          res;
    logic [VAL_W:0]     sum_wide;
    logic               accept;

    assign used = (bucket_count_reg > CFG_W'(MAX_BUCKETS)) ? IDX_W'(MAX_BUCKETS)
                                                           : IDX_W'(bucket_count_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, rd_data_reg};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pf_busy_next   = pf_busy_reg;
        pf_addr_next   = pf_addr_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        key_ok_next    = key_ok_reg;
        total_next     = total_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        pend_next      = pend_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        done           = 1'b0;
        res            = '{slot: '0, status: ST_OK, total: '0};

        unique case (state_reg)
            S_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(MAX_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.command;
                    key_ok_next  = (IDX_W'(req.key) < used);
                    idx_next     = '0;
                    sum_next     = '0;
                    pf_busy_next = 1'b0;
                    unique case (req.command)
                        CMD_CLEAR:
                        begin
                            total_next = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_PREFIX:
                        begin
                            state_next = S_PREFIX;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(req.key);
                            state_next = S_RMW;
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                done = 1'b1;
                if (!key_ok_reg)
                begin
                    res.status = ST_KEY_RANGE;
                end
                else if (cmd_reg == CMD_COUNT)
                begin
                    if (total_reg >= TOTAL_W'(MAX_ITEMS))
                    begin
                        res.status = ST_LIMIT;
                    end
                    else
                    begin
                        // The bucket saturates after a prefix; the total still grows.
                        wr_en      = (rd_data_reg < VAL_W'(MAX_ITEMS));
                        wr_addr    = pf_addr_reg;
                        wr_data    = rd_data_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rd_data_reg == '0)
                    begin
                        res.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = pf_addr_reg;
                        wr_data  = rd_data_reg - 1'b1;
                        res.slot = wr_data[SLOT_W-1:0];
                    end
                end
            end
            S_CLEAR:
            begin
                if (idx_reg < used)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[ADDR_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_PREFIX:
            begin
                // Reads run one entry ahead of the write-back of the running sum.
                if (idx_reg < used)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    pf_busy_next = 1'b1;
                    pf_addr_next = idx_reg[ADDR_W-1:0];
                end
                else
                begin
                    pf_busy_next = 1'b0;
                end
                if (pf_busy_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pf_addr_reg;
                    wr_data = (sum_wide > (VAL_W + 1)'(MAX_ITEMS)) ? VAL_W'(MAX_ITEMS)
                                                                   : sum_wide[VAL_W-1:0];
                    sum_next = wr_data;
                end
                else if (idx_reg >= used)
                begin
                    done = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The key address of a count or assign is kept for the write-back.
        if (accept && (req.command == CMD_COUNT || req.command == CMD_ASSIGN))
        begin
            pf_addr_next = ADDR_W'(req.key);
        end

        if (done)
        begin
            res.total = total_next;
            if (out_free)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            idx_reg          <= '0;
            pf_busy_reg      <= 1'b0;
            total_reg        <= '0;
            bucket_count_reg <= CFG_W'(1024);
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pf_busy_reg   <= pf_busy_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                bucket_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pf_addr_reg <= pf_addr_next;
        sum_reg     <= sum_next;
        cmd_reg     <= cmd_next;
        key_ok_reg  <= key_ok_next;
        rsp_reg     <= rsp_next;
        pend_reg    <= pend_next;
    end

endmodule

[hw/rtl/bcss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket counting sort checker
// Port-level checks on the slot unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module bcss_checker
    import bcss_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input bcss_rsp_t        rsp
);

    // A stalled response stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // An error response carries a zero slot.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.slot == '0)
        else $error("error response carries a slot");

    // The item limit is reported only when the total has reached it.
    a_limit_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_LIMIT |-> rsp.total == TOTAL_W'(MAX_ITEMS))
        else $error("limit reported below the item limit");

    // One request at a time: the unit is busy right after taking one.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in flight");

endmodule

bind bucket_counting_sort_slots_unit bcss_checker u_bcss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
